### sv/resp_command_header_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Request command parser assertion macros
// Shared assertion forms for the parser core, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef RESP_COMMAND_HEADER_PARSER_CORE_DEFINES_SVH
`define RESP_COMMAND_HEADER_PARSER_CORE_DEFINES_SVH

// check outside reset
`define RCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every edge, reset included
`define RCP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/rcp_pkg.sv
// ----------------------------------------------------------------------------
// Request command parser package
// Phase codes, byte constants, window size and shared state/result types.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int unsigned MaxReqBytes = 64;
  localparam int unsigned Window      = MaxReqBytes - 2;
  localparam int unsigned SeenW       = $clog2(Window + 1);
  localparam int unsigned LenW        = 6;

  localparam logic [SeenW-1:0] WindowCnt = SeenW'(Window);
  localparam logic [LenW-1:0]  LenMax    = {LenW{1'b1}};

  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChDel     = 8'h7F;
  localparam logic [7:0] CaseDelta = ChLowerA - ChUpperA;

  typedef enum logic [2:0] {
    PH_STAR  = 3'd0,
    PH_COUNT = 3'd1,
    PH_LEN   = 3'd2,
    PH_CMD   = 3'd3,
    PH_OK    = 3'd4,
    PH_ERR   = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [SeenW-1:0]  seen;
    logic [LenW-1:0]   letters;
  } state_t;

  typedef struct packed {
    logic              letter_valid;
    logic [7:0]        command_letter;
    logic              verdict_valid;
    logic              recognized;
    logic [LenW-1:0]   command_length;
  } result_t;

endpackage

### sv/resp_command_header_parser_core.sv
// ----------------------------------------------------------------------------
// Request command header parser core
// Checks the array header of a request and captures the command name.
// ----------------------------------------------------------------------------
// Input channel: one message byte per beat (data_byte_i) with last_byte_i
// marking the final byte of a message. Output channel: one result beat per
// input beat, carrying any captured upper-case command letter, the running
// command length and, on the final byte, the verdict (recognized_o).
// A result is registered and appears in the cycle after its byte is
// taken, from the result register. Throughput: one byte per cycle while
// the receiver does not stall; the parser state is updated from each byte.
// Only the first MaxReqBytes - 2 bytes of a message are examined; later
// bytes pass through without changing state. Parse errors are sticky until
// the final byte, after which the parser returns to the header start.
// Reset clears the parser to the header start and the output valid, not
// the result data. When the receiver stalls, the result holds and a new
// byte is taken only once the held result is taken in the same cycle.
// ----------------------------------------------------------------------------
`include "resp_command_header_parser_core_defines.svh"

module resp_command_header_parser_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      letter_valid_o,
  output logic [7:0]                command_letter_o,
  output logic                      verdict_valid_o,
  output logic                      recognized_o,
  output logic [rcp_pkg::LenW-1:0]  command_length_o
);

  rcp_pkg::state_t  state_q, state_d;
  rcp_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             in_acc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  rcp_step u_step (
    .state_i     (state_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase   <= rcp_pkg::PH_STAR;
      state_q.seen    <= '0;
      state_q.letters <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign letter_valid_o   = res_q.letter_valid;
  assign command_letter_o = res_q.command_letter;
  assign verdict_valid_o  = res_q.verdict_valid;
  assign recognized_o     = res_q.recognized;
  assign command_length_o = res_q.command_length;

  `RCP_ASSERT(a_letter_upper, out_valid_q && res_q.letter_valid |-> res_q.command_letter >= rcp_pkg::ChUpperA && res_q.command_letter <= rcp_pkg::ChUpperZ, "captured letter not upper case")
  `RCP_ASSERT(a_letter_zero, out_valid_q && !res_q.letter_valid |-> res_q.command_letter == 8'h00, "letter nonzero without capture")
  `RCP_ASSERT(a_recog_verdict, out_valid_q && res_q.recognized |-> res_q.verdict_valid, "recognized outside a verdict")
  `RCP_ASSERT(a_last_resets, in_acc && last_byte_i |=> state_q.phase == rcp_pkg::PH_STAR && state_q.seen == '0 && state_q.letters == '0, "parser not cleared after last byte")
  `RCP_ASSERT(a_seen_window, state_q.seen <= rcp_pkg::WindowCnt, "byte count beyond window")

endmodule

### sv/rcp_step.sv
// ----------------------------------------------------------------------------
// Request command parser step
// Next parser state and result for one byte, from the current state.
// ----------------------------------------------------------------------------
module rcp_step (
  input  rcp_pkg::state_t  state_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output rcp_pkg::state_t  state_o,
  output rcp_pkg::result_t result_o
);

  logic            examine;
  logic            is_digit;
  logic            is_letter;
  logic [7:0]      folded;
  rcp_pkg::state_t parsed;
  logic            letter_hit;

  assign examine  = state_i.seen < rcp_pkg::WindowCnt;
  assign is_digit = (data_byte_i >= rcp_pkg::ChZero) && (data_byte_i <= rcp_pkg::ChNine);
  assign folded   = ((data_byte_i >= rcp_pkg::ChLowerA) && (data_byte_i <= rcp_pkg::ChDel))
                    ? (data_byte_i - rcp_pkg::CaseDelta) : data_byte_i;
  assign is_letter = (folded >= rcp_pkg::ChUpperA) && (folded <= rcp_pkg::ChUpperZ);

  always_comb begin
    parsed     = state_i;
    letter_hit = 1'b0;
    if (examine) begin
      parsed.seen = state_i.seen + 1'b1;
      unique case (state_i.phase)
        rcp_pkg::PH_STAR: begin
          parsed.phase = (data_byte_i == rcp_pkg::ChStar) ? rcp_pkg::PH_COUNT
                                                          : rcp_pkg::PH_ERR;
        end
        rcp_pkg::PH_COUNT: begin
          priority if (is_digit || data_byte_i == rcp_pkg::ChCr ||
                       data_byte_i == rcp_pkg::ChLf) begin
            parsed.phase = rcp_pkg::PH_COUNT;
          end else if (data_byte_i == rcp_pkg::ChDollar) begin
            parsed.phase = rcp_pkg::PH_LEN;
          end else begin
            parsed.phase = rcp_pkg::PH_ERR;
          end
        end
        rcp_pkg::PH_LEN: begin
          priority if (is_digit || data_byte_i == rcp_pkg::ChCr) begin
            parsed.phase = rcp_pkg::PH_LEN;
          end else if (data_byte_i == rcp_pkg::ChLf) begin
            parsed.phase = rcp_pkg::PH_CMD;
          end else begin
            parsed.phase = rcp_pkg::PH_ERR;
          end
        end
        rcp_pkg::PH_CMD: begin
          priority if (is_letter) begin
            letter_hit = 1'b1;
            if (state_i.letters != rcp_pkg::LenMax) begin
              parsed.letters = state_i.letters + 1'b1;
            end
          end else if (folded == rcp_pkg::ChCr || folded == rcp_pkg::ChLf) begin
            parsed.phase = rcp_pkg::PH_OK;
          end else begin
            parsed.phase = rcp_pkg::PH_ERR;
          end
        end
        default: begin
          parsed.phase = state_i.phase;
        end
      endcase
    end
  end

  always_comb begin
    result_o.letter_valid   = letter_hit;
    result_o.command_letter = letter_hit ? folded : 8'h00;
    result_o.verdict_valid  = last_byte_i;
    result_o.recognized     = last_byte_i && (parsed.phase == rcp_pkg::PH_OK);
    result_o.command_length = parsed.letters;
  end

  always_comb begin
    if (last_byte_i) begin
      state_o.phase   = rcp_pkg::PH_STAR;
      state_o.seen    = '0;
      state_o.letters = '0;
    end else begin
      state_o = parsed;
    end
  end

endmodule
